// File: hdl/psf_pkg.sv
// Package for the particle swarm potential fit block.
// Holds shared types, codes and default constants; depends on nothing.
package psf_pkg;

  localparam int NODES_DEFAULT     = 7;
  localparam int PARTICLES_DEFAULT = 128;
  localparam int GAIN_W            = 18;

  localparam logic [GAIN_W-1:0] INERTIA_RESET  = 18'd45875;
  localparam logic [GAIN_W-1:0] PERSONAL_RESET = 18'd91750;
  localparam logic [GAIN_W-1:0] GROUP_RESET    = 18'd91750;

  localparam logic [1:0] REG_INERTIA  = 2'd0;
  localparam logic [1:0] REG_PERSONAL = 2'd1;
  localparam logic [1:0] REG_GROUP    = 2'd2;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_TARGET = 2'd2;

  // Classified command handed from the front part to the back part.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_LOAD_LAST,
    CMD_STEP,
    CMD_TARGET
  } cmd_t;

  typedef struct packed {
    cmd_t         cmd;
    logic [7:0]   particle;
    logic [3:0]   row;
    logic [3:0]   column;
    logic [31:0]  first_value;
    logic [31:0]  second_value;
    logic [15:0]  rand_personal;
    logic [15:0]  rand_group;
    logic         end_of_sweep;
  } work_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_GATH_RD,
    ST_GATH_WR,
    ST_VEL_RD,
    ST_VEL_MUL,
    ST_VEL_WR,
    ST_FIT_RD,
    ST_FIT_MUL,
    ST_FIT_DONE,
    ST_REPORT,
    ST_COMMIT,
    ST_EMIT,
    ST_COPY
  } state_t;

endpackage

// File: hdl/psf_front.sv
// Front part: accepts requests, range-checks and classifies them, queues them.
// Depends on psf_pkg.
module psf_front
  import psf_pkg::*;
#(
  parameter int NODES     = NODES_DEFAULT,
  parameter int PARTICLES = PARTICLES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  particle,
  input  logic [3:0]  row,
  input  logic [3:0]  column,
  input  logic [31:0] first_value,
  input  logic [31:0] second_value,
  input  logic [15:0] rand_personal,
  input  logic [15:0] rand_group,
  input  logic        end_of_sweep,
  output logic        work_valid,
  input  logic        work_ready,
  output work_t       work
);

  localparam int DEPTH = 2;

  work_t      queue [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  work_t      incoming;
  logic       push;
  logic       pop;
  logic       p_ok;
  logic       row_ok;
  logic       col_ok;

  // Range checks decide whether the request does any work of its own.
  assign p_ok   = {1'b0, particle} < 9'(PARTICLES);
  assign row_ok = {1'b0, row} < 5'(NODES);
  assign col_ok = {1'b0, column} < 5'(NODES);

  // Classify the request into a back-end command.
  always_comb begin
    incoming.particle      = particle;
    incoming.row           = row;
    incoming.column        = column;
    incoming.first_value   = first_value;
    incoming.second_value  = second_value;
    incoming.rand_personal = rand_personal;
    incoming.rand_group    = rand_group;
    incoming.end_of_sweep  = end_of_sweep;
    incoming.cmd           = CMD_NONE;
    case (mode)
      MODE_LOAD: begin
        if (p_ok && row_ok) begin
          incoming.cmd = ({1'b0, row} == 5'(NODES - 1)) ? CMD_LOAD_LAST : CMD_LOAD;
        end
      end
      MODE_STEP: begin
        if (p_ok) incoming.cmd = CMD_STEP;
      end
      MODE_TARGET: begin
        if (row_ok && col_ok) incoming.cmd = CMD_TARGET;
      end
      default: incoming.cmd = CMD_NONE;
    endcase
  end

  assign in_ready   = count != 2'(DEPTH);
  assign push       = in_valid && in_ready;
  assign work_valid = count != 2'd0;
  assign pop        = work_valid && work_ready;
  assign work       = queue[rd_ptr];

  // Short queue between the two parts.
  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= incoming;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: hdl/psf_back.sv
// Back part: holds the swarm stores and runs the update, fitness and commit
// sequence; the fitness pass shares one square unit. Depends on psf_pkg.
module psf_back
  import psf_pkg::*;
#(
  parameter int NODES     = NODES_DEFAULT,
  parameter int PARTICLES = PARTICLES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [GAIN_W-1:0] cfg_data,
  input  logic              work_valid,
  output logic              work_ready,
  input  work_t             work,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              result_kind,
  output logic [7:0]        index,
  output logic [63:0]       fitness,
  output logic [31:0]       coordinate,
  output logic              improved,
  output logic [63:0]       group_fitness,
  output logic              last
);

  localparam int NW    = $clog2(NODES);
  localparam int PW    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int DEPTH = PARTICLES * NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(NODES * NODES);
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

  // Memories.
  logic [31:0] pos_mem   [DEPTH];
  logic [31:0] vel_mem   [DEPTH];
  logic [31:0] pbp_mem   [DEPTH];
  logic [63:0] pbf_mem   [PARTICLES];
  logic [31:0] tgt_mem   [NODES * NODES];
  logic [31:0] gbest_pos [NODES];
  logic [31:0] smin_pos  [NODES];
  logic [31:0] cur_pos   [NODES];
  logic [63:0] gbest_fit;
  logic [63:0] smin_fit;

  logic [GAIN_W-1:0] inertia_gain;
  logic [GAIN_W-1:0] personal_gain;
  logic [GAIN_W-1:0] group_gain;

  state_t state, state_next;
  work_t  job;
  logic [NW-1:0] k;
  logic [NW-1:0] j;
  logic [GAIN_W-1:0] gain_a;
  logic [GAIN_W-1:0] gain_b;
  logic [31:0] rd_pos;
  logic [31:0] rd_vel;
  logic [31:0] rd_pbp;
  logic [31:0] rd_tgt;
  logic [63:0] rd_pbf;
  logic [49:0] prod_p;
  logic [49:0] prod_g;
  logic [63:0] sq;
  logic        sq_sat;
  logic [63:0] acc;
  logic [63:0] fit_final;
  logic        upd;
  logic        imp;
  logic        res_pending;
  logic        res_load;

  logic [AW-1:0] base_addr;
  logic [AW-1:0] node_addr;
  logic [TW-1:0] tgt_addr;

  assign base_addr = AW'(job.particle[PW-1:0]) * AW'(NODES);
  assign node_addr = base_addr + AW'(k);
  assign tgt_addr  = TW'(k) * TW'(NODES) + TW'(j);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_gain  <= INERTIA_RESET;
      personal_gain <= PERSONAL_RESET;
      group_gain    <= GROUP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INERTIA:  inertia_gain  <= cfg_data;
        REG_PERSONAL: personal_gain <= cfg_data;
        REG_GROUP:    group_gain    <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Velocity arithmetic, combined from registered products.
  logic signed [33:0] dp;
  logic signed [33:0] dg;
  logic signed [68:0] vsum;
  logic signed [52:0] vround;
  logic signed [31:0] new_vel;
  logic signed [32:0] psum;
  logic signed [31:0] new_pos;
  logic signed [33:0] resid;
  logic [33:0]        resid_mag;
  logic [64:0]        acc_sum;

  assign dp = 34'(signed'(rd_pbp)) - 34'(signed'(rd_pos));
  assign dg = 34'(signed'(gbest_pos[k])) - 34'(signed'(rd_pos));

  logic signed [52:0] mul_v;
  logic signed [52:0] mul_p;
  logic signed [52:0] mul_g;
  always_ff @(posedge clk) begin
    mul_v <= 53'(signed'({1'b0, inertia_gain})) * 53'(signed'(rd_vel));
    mul_p <= 53'(signed'({1'b0, gain_a})) * 53'(dp);
    mul_g <= 53'(signed'({1'b0, gain_b})) * 53'(dg);
  end

  always_comb begin
    vsum   = 69'(mul_v) + 69'(mul_p) + 69'(mul_g) + 69'sd32768;
    vround = 53'(vsum >>> 16);
    if (vsum > 69'sh7FFFFFFF_FFFF) new_vel = 32'sh7FFFFFFF;
    else if (vsum < -69'sh80000000_0000) new_vel = 32'sh80000000;
    else new_vel = 32'(vround);
    psum = 33'(signed'(rd_pos)) + 33'(new_vel);
    if (psum > 33'sh7FFFFFFF) new_pos = 32'sh7FFFFFFF;
    else if (psum < -33'sh80000000) new_pos = 32'sh80000000;
    else new_pos = 32'(psum);
  end

  // Residual and square for one pair.
  assign resid     = 34'(signed'(cur_pos[k])) - 34'(signed'(cur_pos[j]))
                   - 34'(signed'(rd_tgt));
  assign resid_mag = resid[33] ? 34'(-resid) : 34'(resid);
  always_ff @(posedge clk) begin
    sq     <= resid_mag[31:0] * resid_mag[31:0];
    sq_sat <= resid_mag[33:32] != 2'b00;
  end
  assign acc_sum   = {1'b0, acc} + {1'b0, sq};
  // Running sum with the registered square folded in, saturating at all ones.
  assign fit_final = (sq_sat || acc_sum[64]) ? ALL_ONES : acc_sum[63:0];

  assign prod_p = 50'(personal_gain * work.rand_personal);
  assign prod_g = 50'(group_gain * work.rand_group);

  // A result is loaded into the output register when it is free or draining.
  assign res_load = ((state == ST_REPORT) || (state == ST_EMIT)) &&
                    (!res_pending || out_ready);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (work_valid) begin
          case (work.cmd)
            CMD_LOAD, CMD_LOAD_LAST, CMD_TARGET: state_next = ST_LOAD;
            CMD_STEP: state_next = ST_VEL_RD;
            default: state_next = work.end_of_sweep ? ST_COMMIT : ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (job.cmd == CMD_LOAD_LAST) state_next = ST_GATH_RD;
        else state_next = job.end_of_sweep ? ST_COMMIT : ST_IDLE;
      end
      ST_GATH_RD: state_next = ST_GATH_WR;
      ST_GATH_WR: state_next = (k == LAST_NODE) ? ST_FIT_RD : ST_GATH_RD;
      ST_VEL_RD:  state_next = ST_VEL_MUL;
      ST_VEL_MUL: state_next = ST_VEL_WR;
      ST_VEL_WR:  state_next = (k == LAST_NODE) ? ST_FIT_RD : ST_VEL_RD;
      ST_FIT_RD:  state_next = ST_FIT_MUL;
      ST_FIT_MUL: state_next = (k == LAST_NODE && j == LAST_NODE) ? ST_FIT_DONE : ST_FIT_RD;
      ST_FIT_DONE: state_next = ST_COPY;
      ST_COPY: begin
        if (k == LAST_NODE) begin
          if (job.cmd == CMD_STEP) state_next = ST_REPORT;
          else state_next = job.end_of_sweep ? ST_COMMIT : ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (res_load) state_next = job.end_of_sweep ? ST_COMMIT : ST_IDLE;
      end
      ST_COMMIT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (res_load && k == LAST_NODE) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Work input handshake decode.
  always_comb begin
    work_ready = state == ST_IDLE;
  end

  // Sequencer registers and datapath.
  always_ff @(posedge clk) begin
    rd_pos <= pos_mem[node_addr];
    rd_vel <= vel_mem[node_addr];
    rd_pbp <= pbp_mem[node_addr];
    rd_tgt <= tgt_mem[tgt_addr];
    rd_pbf <= pbf_mem[job.particle[PW-1:0]];
    if (rst) begin
      state       <= ST_IDLE;
      res_pending <= 1'b0;
      gbest_fit   <= ALL_ONES;
      smin_fit    <= ALL_ONES;
      for (int n = 0; n < NODES; n++) begin
        gbest_pos[n] <= '0;
        smin_pos[n]  <= '0;
      end
      k <= '0;
      j <= '0;
    end else begin
      state <= state_next;
      if (res_load) res_pending <= 1'b1;
      else if (out_valid && out_ready) res_pending <= 1'b0;
      case (state)
        ST_IDLE: begin
          job    <= work;
          k      <= (work.cmd == CMD_STEP) ? '0 : work.row[NW-1:0];
          j      <= '0;
          gain_a <= GAIN_W'(prod_p >> 16);
          gain_b <= GAIN_W'(prod_g >> 16);
        end
        ST_LOAD: begin
          if (job.cmd == CMD_TARGET) begin
            tgt_mem[TW'(job.row[NW-1:0]) * TW'(NODES) + TW'(job.column[NW-1:0])]
              <= job.first_value;
          end else begin
            pos_mem[node_addr] <= job.first_value;
            vel_mem[node_addr] <= job.second_value;
            pbp_mem[node_addr] <= job.first_value;
            cur_pos[k]         <= job.first_value;
          end
          k   <= '0;
          j   <= '0;
          acc <= '0;
        end
        // Gather the particle's stored coordinates for its fitness pass.
        ST_GATH_WR: begin
          cur_pos[k] <= rd_pos;
          k <= (k == LAST_NODE) ? '0 : k + 1'b1;
        end
        ST_VEL_WR: begin
          vel_mem[node_addr] <= new_vel;
          pos_mem[node_addr] <= new_pos;
          cur_pos[k]         <= new_pos;
          k   <= (k == LAST_NODE) ? '0 : k + 1'b1;
          acc <= '0;
          j   <= '0;
        end
        // Accumulate the square registered in the previous pair's multiply state.
        ST_FIT_RD: begin
          if (!(k == '0 && j == '0)) acc <= fit_final;
        end
        ST_FIT_MUL: begin
          if (j == LAST_NODE) begin
            j <= '0;
            k <= k + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        // The final square is folded in here.
        ST_FIT_DONE: begin
          k   <= '0;
          acc <= fit_final;
          imp <= (job.cmd != CMD_STEP) || (fit_final < rd_pbf);
          if ((job.cmd != CMD_STEP) || (fit_final < rd_pbf)) begin
            pbf_mem[job.particle[PW-1:0]] <= fit_final;
          end
          if (fit_final < smin_fit) begin
            smin_fit <= fit_final;
            for (int n = 0; n < NODES; n++) smin_pos[n] <= cur_pos[n];
          end
        end
        ST_COPY: begin
          if (imp) pbp_mem[node_addr] <= cur_pos[k];
          k <= (k == LAST_NODE) ? '0 : k + 1'b1;
        end
        ST_REPORT: begin
          if (res_load) begin
            result_kind   <= 1'b0;
            index         <= job.particle;
            fitness       <= acc;
            coordinate    <= '0;
            improved      <= imp;
            group_fitness <= gbest_fit;
            last          <= !job.end_of_sweep;
          end
        end
        ST_COMMIT: begin
          upd <= smin_fit < gbest_fit;
          if (smin_fit < gbest_fit) begin
            gbest_fit <= smin_fit;
            for (int n = 0; n < NODES; n++) gbest_pos[n] <= smin_pos[n];
          end
          smin_fit <= ALL_ONES;
          k <= '0;
        end
        ST_EMIT: begin
          if (res_load) begin
            result_kind   <= 1'b1;
            index         <= 8'(k);
            fitness       <= '0;
            coordinate    <= gbest_pos[k];
            improved      <= upd;
            group_fitness <= gbest_fit;
            last          <= k == LAST_NODE;
            k             <= k + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = res_pending;

endmodule

// File: hdl/particle_swarm_potential_fit.sv
// Top level of the particle swarm potential fit block.
// Depends on psf_pkg, psf_front and psf_back.
//
// A step request is paced by the shared square unit, which walks every node
// pair one after another, and the result port can stall it; a load passes
// through a single load state, the last coordinate of a particle also gathers
// its stored coordinates and runs the fitness pass, and an end of sweep adds
// the commit and the coordinate results. A two-entry queue decouples the
// request port from the sequencer.
module particle_swarm_potential_fit
  import psf_pkg::*;
#(
  parameter int NODES     = NODES_DEFAULT,
  parameter int PARTICLES = PARTICLES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [GAIN_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [7:0]        particle,
  input  logic [3:0]        row,
  input  logic [3:0]        column,
  input  logic [31:0]       first_value,
  input  logic [31:0]       second_value,
  input  logic [15:0]       rand_personal,
  input  logic [15:0]       rand_group,
  input  logic              end_of_sweep,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              result_kind,
  output logic [7:0]        index,
  output logic [63:0]       fitness,
  output logic [31:0]       coordinate,
  output logic              improved,
  output logic [63:0]       group_fitness,
  output logic              last
);

  logic  work_valid;
  logic  work_ready;
  work_t work;

  psf_front #(.NODES(NODES), .PARTICLES(PARTICLES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .mode, .particle, .row, .column,
    .first_value, .second_value, .rand_personal, .rand_group, .end_of_sweep,
    .work_valid, .work_ready, .work
  );

  psf_back #(.NODES(NODES), .PARTICLES(PARTICLES)) u_back (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .work_valid, .work_ready,
    .work, .out_valid, .out_ready, .result_kind, .index, .fitness, .coordinate,
    .improved, .group_fitness, .last
  );

endmodule

// File: sim/tb_particle_swarm_potential_fit.sv
// Testbench for the particle swarm potential fit block: drives load, target,
// step and invalid-mode requests and gain writes, predicts every result in a scoreboard class and checks them.
// Depends on psf_pkg and the particle_swarm_potential_fit RTL.
`timescale 1ns / 100ps

module tb_particle_swarm_potential_fit;
  import psf_pkg::*;

  localparam int N = 7;
  localparam int P = 128;
  localparam longint unsigned ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] particle;
    logic [3:0] row;
    logic [3:0] column;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [15:0] rand_personal;
    logic [15:0] rand_group;
    logic end_of_sweep;
  } request_t;

  typedef struct {
    logic result_kind;
    logic [7:0] index;
    logic [63:0] fitness;
    logic [31:0] coordinate;
    logic improved;
    logic [63:0] group_fitness;
    logic last;
  } swarm_result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = REG_INERTIA;
  logic [17:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] mode = 0;
  logic [7:0] particle = 0;
  logic [3:0] row = 0;
  logic [3:0] column = 0;
  logic [31:0] first_value = 0;
  logic [31:0] second_value = 0;
  logic [15:0] rand_personal = 0;
  logic [15:0] rand_group = 0;
  logic end_of_sweep = 0;
  logic out_valid;
  logic out_ready = 0;
  logic result_kind;
  logic [7:0] index;
  logic [63:0] fitness;
  logic [31:0] coordinate;
  logic improved;
  logic [63:0] group_fitness;
  logic last;

  int mismatch_count = 0;
  longint cycle_count = 0;
  bit stall_enable = 1;

  particle_swarm_potential_fit dut (.*);

  always #6 clk = ~clk;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Swarm predictor and the queue of results it still expects.
  class swarm_scoreboard;
    logic [17:0] inertia, pgain, ggain;
    logic signed [31:0] pos[P*N], vel[P*N], pbest[P*N];
    logic [63:0] pbest_fit[P];
    logic signed [31:0] target[N*N];
    logic signed [31:0] gbest[N], sweep_pos[N];
    logic [63:0] gbest_fit, sweep_fit;
    swarm_result_t pending[$];

    function void clear();
      inertia = INERTIA_RESET;
      pgain = PERSONAL_RESET;
      ggain = GROUP_RESET;
      foreach (pos[i]) begin
        pos[i] = 0; vel[i] = 0; pbest[i] = 0;
      end
      foreach (pbest_fit[i]) pbest_fit[i] = 0;
      foreach (target[i]) target[i] = 0;
      foreach (gbest[i]) begin
        gbest[i] = 0; sweep_pos[i] = 0;
      end
      gbest_fit = ONES;
      sweep_fit = ONES;
    endfunction

    function void set_gain(logic [1:0] idx, logic [17:0] val);
      case (idx)
        REG_INERTIA: inertia = val;
        REG_PERSONAL: pgain = val;
        REG_GROUP: ggain = val;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    // Sum of saturated squared residuals over all node pairs.
    function logic [63:0] potential_error(int base);
      logic [63:0] acc, sq;
      logic signed [63:0] e;
      logic [63:0] m;
      acc = 0;
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++) begin
          e = 64'(pos[base+i]) - 64'(pos[base+j]) - 64'(target[i*N+j]);
          m = e < 0 ? -e : e;
          sq = (m >= 64'h1_0000_0000) ? ONES : m * m;
          acc = acc + sq;
          if (acc < sq) acc = ONES;
        end
      return acc;
    endfunction

    function void fold(logic [63:0] f, int base);
      if (f < sweep_fit) begin
        sweep_fit = f;
        for (int k = 0; k < N; k++) sweep_pos[k] = pos[base+k];
      end
    endfunction

    function void push(logic kind, logic [7:0] idx, logic [63:0] f,
                       logic [31:0] c, logic imp);
      swarm_result_t r;
      r.result_kind = kind; r.index = idx; r.fitness = f; r.coordinate = c;
      r.improved = imp; r.group_fitness = gbest_fit; r.last = 0;
      pending.push_back(r);
    endfunction

    // Notes an accepted request and queues its expected results.
    function void note_request(request_t q);
      int base, start_len;
      logic [63:0] f;
      logic signed [63:0] a, b, x, acc, sh;
      logic signed [31:0] nv;
      logic imp;
      start_len = pending.size();
      base = q.particle * N;
      if (q.mode == MODE_LOAD) begin
        if (q.particle < P && q.row < N) begin
          pos[base+q.row] = q.first_value;
          vel[base+q.row] = q.second_value;
          pbest[base+q.row] = q.first_value;
          if (q.row == N-1) begin
            f = potential_error(base);
            pbest_fit[q.particle] = f;
            for (int k = 0; k < N; k++) pbest[base+k] = pos[base+k];
            fold(f, base);
          end
        end
      end else if (q.mode == MODE_TARGET) begin
        if (q.row < N && q.column < N) target[q.row*N+q.column] = q.first_value;
      end else if (q.mode == MODE_STEP) begin
        if (q.particle < P) begin
          a = (64'(pgain) * 64'(q.rand_personal)) >>> 16;
          b = (64'(ggain) * 64'(q.rand_group)) >>> 16;
          for (int k = 0; k < N; k++) begin
            x = 64'(pos[base+k]);
            acc = 64'(inertia) * 64'(vel[base+k]) + a * (64'(pbest[base+k]) - x)
                  + b * (64'(gbest[k]) - x);
            sh = (acc + 32768) >>> 16;
            nv = clamp32(sh);
            vel[base+k] = nv;
            pos[base+k] = clamp32(x + 64'(nv));
          end
          f = potential_error(base);
          imp = f < pbest_fit[q.particle];
          if (imp) begin
            pbest_fit[q.particle] = f;
            for (int k = 0; k < N; k++) pbest[base+k] = pos[base+k];
          end
          fold(f, base);
          push(0, q.particle, f, 0, imp);
        end
      end
      if (q.end_of_sweep) begin
        imp = sweep_fit < gbest_fit;
        if (imp) begin
          gbest_fit = sweep_fit;
          for (int k = 0; k < N; k++) gbest[k] = sweep_pos[k];
        end
        sweep_fit = ONES;
        for (int k = 0; k < N; k++) push(1, 8'(k), 0, gbest[k], imp);
      end
      if (pending.size() > start_len) pending[$].last = 1;
    endfunction

    // Compares one accepted result with the oldest expectation.
    task check_result(swarm_result_t got);
      swarm_result_t w;
      if (pending.size() == 0) begin
        report_mismatch("result with none expected");
        return;
      end
      w = pending.pop_front();
      if (got.result_kind !== w.result_kind)
        report_mismatch($sformatf("kind %0d want %0d", got.result_kind, w.result_kind));
      if (got.index !== w.index)
        report_mismatch($sformatf("index %0d want %0d", got.index, w.index));
      if (got.fitness !== w.fitness)
        report_mismatch($sformatf("fitness %h want %h", got.fitness, w.fitness));
      if (got.coordinate !== w.coordinate)
        report_mismatch($sformatf("coordinate %h want %h", got.coordinate, w.coordinate));
      if (got.improved !== w.improved)
        report_mismatch($sformatf("improved %0d want %0d", got.improved, w.improved));
      if (got.group_fitness !== w.group_fitness)
        report_mismatch($sformatf("group fitness %h want %h",
                                  got.group_fitness, w.group_fitness));
      if (got.last !== w.last)
        report_mismatch($sformatf("last %0d want %0d", got.last, w.last));
    endtask
  endclass

  swarm_scoreboard board = new();
  bit loaded[P];

  // Result side: check at the rising edge; the stall pattern is set at the falling edge.
  always @(posedge clk) begin
    swarm_result_t got;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      got.result_kind = result_kind; got.index = index; got.fitness = fitness;
      got.coordinate = coordinate; got.improved = improved;
      got.group_fitness = group_fitness; got.last = last;
      board.check_result(got);
    end
  end

  always @(negedge clk) begin
    if (!stall_enable) out_ready <= 1;
    else out_ready <= (cycle_count % 23 < 15) ? ($urandom_range(0, 3) != 0) : 1'b0;
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Presents one request and waits for acceptance.
  task automatic send_request(input request_t q);
    @(negedge clk);
    mode <= q.mode; particle <= q.particle; row <= q.row; column <= q.column;
    first_value <= q.first_value; second_value <= q.second_value;
    rand_personal <= q.rand_personal; rand_group <= q.rand_group;
    end_of_sweep <= q.end_of_sweep;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    board.note_request(q);
    @(negedge clk);
    in_valid <= 0;
  endtask

  function automatic request_t make_request(logic [1:0] m, int p, int r, int c,
                                            logic [31:0] v1, logic [31:0] v2,
                                            logic eos);
    request_t q;
    q.mode = m; q.particle = 8'(p); q.row = 4'(r); q.column = 4'(c);
    q.first_value = v1; q.second_value = v2;
    q.rand_personal = 16'($urandom); q.rand_group = 16'($urandom);
    q.end_of_sweep = eos;
    return q;
  endfunction

  // Small coordinate values keep the swarm in range; some are extreme.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    endcase
  endfunction

  task automatic load_particle(input int p, input logic eos);
    for (int k = 0; k < N; k++)
      send_request(make_request(MODE_LOAD, p, k, 0, rand_value(), rand_value(),
                                eos && k == N-1));
    loaded[p] = 1;
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_gain(input logic [1:0] idx, input logic [17:0] val);
    @(negedge clk);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    board.set_gain(idx, val);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  task automatic random_gap();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  initial begin
    request_t q;
    int p;
    board.clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: full target table, extremes, all modes and out-of-range cases.
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++)
        send_request(make_request(MODE_TARGET, 0, i, j, rand_value(), 0, 0));
    send_request(make_request(MODE_TARGET, 255, 0, 1, 32'h7FFF_FFFF, 0, 0));
    send_request(make_request(MODE_TARGET, 0, 1, 0, 32'h8000_0000, 0, 0));
    send_request(make_request(MODE_TARGET, 0, 15, 15, 32'hFFFF_FFFF, 0, 0));
    send_request(make_request(2'd3, 0, 0, 0, 0, 0, 1));
    load_particle(0, 0);
    load_particle(P-1, 1);
    q = make_request(MODE_STEP, 0, 0, 0, 0, 0, 1);
    q.rand_personal = 16'hFFFF; q.rand_group = 16'hFFFF;
    send_request(q);
    q = make_request(MODE_STEP, P-1, 0, 0, 0, 0, 0);
    q.rand_personal = 0; q.rand_group = 0;
    send_request(q);
    send_request(make_request(MODE_STEP, 200, 0, 0, 0, 0, 1));
    send_request(make_request(MODE_LOAD, 255, 15, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    send_request(make_request(MODE_STEP, 255, 0, 0, 0, 0, 0));
    wait_drained();

    // Random phases under several gain settings, extremes included.
    stall_enable = 1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_gain(REG_INERTIA, 18'h3FFFF); write_gain(REG_PERSONAL, 0);
          write_gain(REG_GROUP, 18'h3FFFF);
        end
        1: begin
          write_gain(REG_INERTIA, 0); write_gain(REG_PERSONAL, 18'h3FFFF);
          write_gain(REG_GROUP, 0);
        end
        2: begin
          write_gain(REG_INERTIA, 18'($urandom)); write_gain(REG_PERSONAL, 18'($urandom));
          write_gain(REG_GROUP, 18'($urandom));
        end
        default: begin
          write_gain(REG_INERTIA, INERTIA_RESET); write_gain(REG_PERSONAL, PERSONAL_RESET);
          write_gain(REG_GROUP, GROUP_RESET);
          stall_enable = 0;
        end
      endcase
      for (int n = 0; n < 85; n++) begin
        random_gap();
        case ($urandom_range(0, 19))
          0: send_request(make_request(MODE_TARGET, $urandom, $urandom_range(0, 15),
                                       $urandom_range(0, 15), rand_value(), $urandom,
                                       1'($urandom_range(0, 1))));
          1: begin
            load_particle($urandom_range(0, P-1), 1'($urandom_range(0, 1)));
            n += N-1;
          end
          2: send_request(make_request(MODE_LOAD, $urandom_range(P, 255),
                                       $urandom_range(0, 15), 0, $urandom, $urandom,
                                       1'($urandom_range(0, 1))));
          3: send_request(make_request(2'd3, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, 1'($urandom_range(0, 1))));
          default: begin
            // Step a particle that has been loaded, sometimes closing the sweep.
            do p = $urandom_range(0, P-1); while (!loaded[p] && $urandom_range(0, 7) != 0);
            if (!loaded[p]) begin
              load_particle(p, 0);
              n += N;
            end
            q = make_request(MODE_STEP, p, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(0, 5) == 0);
            send_request(q);
          end
        endcase
      end
      // Hold off until every expected result has come.
      wait_drained();
    end

    if (mismatch_count == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
